>>> rtl/bsfrq_pkg.sv
// Package for the byte-stuffed frame ring queue.
// Ring geometry, framing bytes, operation codes, sequencer states and shared types.
// No dependencies.
`default_nettype none

package bsfrq_pkg;

	localparam int RingDepth = 64;
	localparam int PtrW      = $clog2(RingDepth);
	localparam int FillW     = $clog2(RingDepth + 1);

	localparam logic [7:0] FlagOpen  = 8'h7E;
	localparam logic [7:0] FlagClose = 8'h7F;
	localparam logic [7:0] EscByte   = 8'h7D;
	localparam logic [7:0] EscMask   = 8'h20;

	localparam int         DataCntW       = 6;
	localparam logic [5:0] MaxDataResults = 6'd63;

	typedef logic [1:0] op_t;
	localparam op_t OpWrite = 2'd0;
	localparam op_t OpRead  = 2'd1;
	localparam op_t OpEmpty = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_W_OPEN,
		ST_W_BODY,
		ST_W_ESC,
		ST_W_CLOSE,
		ST_W_DONE,
		ST_R_ISSUE,
		ST_R_PROC
	} state_t;

	typedef struct packed {
		logic            en;
		logic [PtrW-1:0] addr;
		logic [7:0]      data;
	} ring_wr_t;

	function automatic logic needs_escape(input logic [7:0] b);
		needs_escape = (b == EscByte) || (b == FlagOpen) || (b == FlagClose);
	endfunction

	function automatic logic [PtrW-1:0] ptr_next(input logic [PtrW-1:0] p);
		ptr_next = (p == PtrW'(RingDepth - 1)) ? '0 : p + 1'b1;
	endfunction

endpackage

`default_nettype wire

>>> rtl/bsfrq_ring_mem.sv
// Byte ring storage: one write port, one read port with registered data.
// Depends on bsfrq_pkg for depth and the write request type.
`default_nettype none

module bsfrq_ring_mem (
	input  wire logic                       clk,
	input  wire bsfrq_pkg::ring_wr_t        wr,
	input  wire logic                       rd_en,
	input  wire logic [bsfrq_pkg::PtrW-1:0] rd_addr,
	output logic [7:0]                      rd_data
);

	logic [7:0] mem [bsfrq_pkg::RingDepth];

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

>>> rtl/byte_stuffed_frame_ring_queue.sv
// Top level of the byte-stuffed frame queue: write/read sequencer around the ring.
// Depends on bsfrq_pkg and bsfrq_ring_mem.
//
// Timing: the ring has one write port, so a write item stores one byte per cycle. It
// steps through the open, body, escape and close states as the frame needs, and its
// result is loaded into the output register from the done state. A read item issues
// one memory read per cycle while the output slot is free, and parses each byte when
// its registered data comes back. When it empties the ring without meeting a closing
// flag, it goes back to issue and reports a failed status. Both kinds of item wait
// while the output side stalls. The ring needs no clearing after reset: the fill count
// keeps reads to written entries.
`default_nettype none

module byte_stuffed_frame_ring_queue (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [15:0] cfg_wdata,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  operation,
	input  wire logic [7:0]  data_byte,
	input  wire logic        first_of_frame,
	input  wire logic        last_of_frame,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [7:0]       out_byte,
	output logic [15:0]      byte_index,
	output logic             is_data,
	output logic             status,
	output logic [15:0]      frame_len,
	output logic             last
);

	localparam int PtrW  = bsfrq_pkg::PtrW;
	localparam int FillW = bsfrq_pkg::FillW;
	localparam int KW    = bsfrq_pkg::DataCntW;

	bsfrq_pkg::state_t state_q, state_d;

	logic [PtrW-1:0]  rptr_q, wptr_q;
	logic [FillW-1:0] fill_q;
	logic [15:0]      enc_q, enc_d;
	logic [15:0]      wlen_q, wlen_d;
	logic             abort_q, abort_d;
	logic             esc_q, esc_d;
	logic             started_q, started_d;
	logic [15:0]      stored_q, stored_d;
	logic [KW-1:0]    k_q, k_d;
	logic [15:0]      max_len_q;

	logic [7:0]       db_q;
	logic             last_q, empty_q;

	logic             out_valid_q;
	logic [7:0]       out_byte_q;
	logic [15:0]      idx_q, len_q;
	logic             is_data_q, status_q, out_last_q;

	logic             accept, full, slot_free;
	logic             put, rd_issue, out_load;
	logic [7:0]       put_data, rd_data, proc_byte;
	logic [7:0]       o_byte;
	logic [15:0]      o_idx, o_len;
	logic             o_data, o_status, o_last;
	logic [16:0]      enc_p1, enc_p2;
	bsfrq_pkg::ring_wr_t ring_wr;

	assign in_ready  = (state_q == bsfrq_pkg::ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign full      = (fill_q == FillW'(bsfrq_pkg::RingDepth));
	assign slot_free = !out_valid_q || out_ready;
	assign enc_p1    = {1'b0, enc_q} + 17'd1;
	assign enc_p2    = {1'b0, enc_q} + 17'd2;
	assign proc_byte = esc_q ? (rd_data ^ bsfrq_pkg::EscMask) : rd_data;

	assign ring_wr.en   = put;
	assign ring_wr.addr = wptr_q;
	assign ring_wr.data = put_data;

	bsfrq_ring_mem u_ring (
		.clk     (clk),
		.wr      (ring_wr),
		.rd_en   (rd_issue),
		.rd_addr (rptr_q),
		.rd_data (rd_data)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			bsfrq_pkg::ST_IDLE: begin
				if (accept) begin
					if (operation == bsfrq_pkg::OpWrite) begin
						state_d = first_of_frame ? bsfrq_pkg::ST_W_OPEN : bsfrq_pkg::ST_W_BODY;
					end else if (operation == bsfrq_pkg::OpEmpty) begin
						state_d = bsfrq_pkg::ST_W_OPEN;
					end else if (operation == bsfrq_pkg::OpRead) begin
						state_d = bsfrq_pkg::ST_R_ISSUE;
					end
				end
			end
			bsfrq_pkg::ST_W_OPEN: begin
				if (full) begin
					state_d = bsfrq_pkg::ST_W_DONE;
				end else begin
					state_d = empty_q ? bsfrq_pkg::ST_W_CLOSE : bsfrq_pkg::ST_W_BODY;
				end
			end
			bsfrq_pkg::ST_W_BODY: begin
				if (abort_q || full) begin
					state_d = bsfrq_pkg::ST_W_DONE;
				end else begin
					state_d = bsfrq_pkg::needs_escape(db_q) ? bsfrq_pkg::ST_W_ESC
						: bsfrq_pkg::ST_W_CLOSE;
				end
			end
			bsfrq_pkg::ST_W_ESC: begin
				state_d = full ? bsfrq_pkg::ST_W_DONE : bsfrq_pkg::ST_W_CLOSE;
			end
			bsfrq_pkg::ST_W_CLOSE: begin
				state_d = bsfrq_pkg::ST_W_DONE;
			end
			bsfrq_pkg::ST_W_DONE: begin
				if (slot_free) begin
					state_d = bsfrq_pkg::ST_IDLE;
				end
			end
			bsfrq_pkg::ST_R_ISSUE: begin
				if (fill_q != '0) begin
					state_d = bsfrq_pkg::ST_R_PROC;
				end else if (slot_free) begin
					state_d = bsfrq_pkg::ST_IDLE;
				end
			end
			bsfrq_pkg::ST_R_PROC: begin
				if (slot_free) begin
					if (rd_data == bsfrq_pkg::FlagClose) begin
						state_d = bsfrq_pkg::ST_IDLE;
					end else if (fill_q == '0) begin
						state_d = bsfrq_pkg::ST_R_ISSUE;
					end
				end
			end
			default: state_d = bsfrq_pkg::ST_IDLE;
		endcase
	end

	// actions
	always_comb begin
		put       = 1'b0;
		put_data  = db_q;
		rd_issue  = 1'b0;
		out_load  = 1'b0;
		o_byte    = '0;
		o_idx     = '0;
		o_data    = 1'b0;
		o_status  = 1'b0;
		o_len     = '0;
		o_last    = 1'b1;
		abort_d   = abort_q;
		enc_d     = enc_q;
		wlen_d    = wlen_q;
		esc_d     = esc_q;
		started_d = started_q;
		stored_d  = stored_q;
		k_d       = k_q;
		case (state_q)
			bsfrq_pkg::ST_IDLE: begin
				if (accept) begin
					wlen_d = '0;
					if (operation == bsfrq_pkg::OpRead) begin
						esc_d     = 1'b0;
						started_d = 1'b0;
						stored_d  = '0;
						k_d       = '0;
					end
				end
			end
			bsfrq_pkg::ST_W_OPEN: begin
				enc_d = 16'd2;
				if (full) begin
					abort_d = 1'b1;
				end else begin
					abort_d  = 1'b0;
					put      = 1'b1;
					put_data = bsfrq_pkg::FlagOpen;
				end
			end
			bsfrq_pkg::ST_W_BODY: begin
				if (!abort_q) begin
					if (full) begin
						abort_d = 1'b1;
					end else if (bsfrq_pkg::needs_escape(db_q)) begin
						put      = 1'b1;
						put_data = bsfrq_pkg::EscByte;
					end else begin
						put   = 1'b1;
						enc_d = enc_p1[16] ? 16'hFFFF : enc_p1[15:0];
					end
				end
			end
			bsfrq_pkg::ST_W_ESC: begin
				if (full) begin
					abort_d = 1'b1;
				end else begin
					put      = 1'b1;
					put_data = db_q ^ bsfrq_pkg::EscMask;
					enc_d    = enc_p2[16] ? 16'hFFFF : enc_p2[15:0];
				end
			end
			bsfrq_pkg::ST_W_CLOSE: begin
				if (last_q) begin
					if (full) begin
						abort_d = 1'b1;
					end else begin
						put      = 1'b1;
						put_data = bsfrq_pkg::FlagClose;
						wlen_d   = enc_q;
					end
				end
			end
			bsfrq_pkg::ST_W_DONE: begin
				if (slot_free) begin
					out_load = 1'b1;
					o_status = abort_q;
					o_len    = wlen_q;
				end
			end
			bsfrq_pkg::ST_R_ISSUE: begin
				if (fill_q != '0) begin
					rd_issue = 1'b1;
				end else if (slot_free) begin
					out_load = 1'b1;
					o_status = 1'b1;
				end
			end
			bsfrq_pkg::ST_R_PROC: begin
				if (slot_free) begin
					if (rd_data == bsfrq_pkg::EscByte) begin
						esc_d = 1'b1;
					end else if (rd_data == bsfrq_pkg::FlagOpen) begin
						stored_d  = '0;
						esc_d     = 1'b0;
						started_d = 1'b1;
					end else if (rd_data == bsfrq_pkg::FlagClose) begin
						started_d = 1'b0;
						out_load  = 1'b1;
						o_len     = stored_q;
					end else if (started_q) begin
						esc_d = 1'b0;
						if ((stored_q < max_len_q) && (k_q < bsfrq_pkg::MaxDataResults)) begin
							out_load = 1'b1;
							o_byte   = proc_byte;
							o_idx    = stored_q;
							o_data   = 1'b1;
							o_last   = 1'b0;
							stored_d = stored_q + 16'd1;
							k_d      = k_q + 1'b1;
						end
					end
					if ((rd_data != bsfrq_pkg::FlagClose) && (fill_q != '0)) begin
						rd_issue = 1'b1;
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= bsfrq_pkg::ST_IDLE;
			rptr_q      <= '0;
			wptr_q      <= '0;
			fill_q      <= '0;
			enc_q       <= '0;
			wlen_q      <= '0;
			abort_q     <= 1'b0;
			esc_q       <= 1'b0;
			started_q   <= 1'b0;
			stored_q    <= '0;
			k_q         <= '0;
			max_len_q   <= 16'd64;
			out_valid_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			enc_q     <= enc_d;
			wlen_q    <= wlen_d;
			abort_q   <= abort_d;
			esc_q     <= esc_d;
			started_q <= started_d;
			stored_q  <= stored_d;
			k_q       <= k_d;
			if (cfg_we) begin
				max_len_q <= cfg_wdata;
			end
			if (put) begin
				wptr_q <= bsfrq_pkg::ptr_next(wptr_q);
				fill_q <= fill_q + 1'b1;
			end else if (rd_issue) begin
				rptr_q <= bsfrq_pkg::ptr_next(rptr_q);
				fill_q <= fill_q - 1'b1;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			db_q    <= data_byte;
			last_q  <= (operation == bsfrq_pkg::OpEmpty) ? 1'b1 : last_of_frame;
			empty_q <= (operation == bsfrq_pkg::OpEmpty);
		end
		if (out_load) begin
			out_byte_q <= o_byte;
			idx_q      <= o_idx;
			is_data_q  <= o_data;
			status_q   <= o_status;
			len_q      <= o_len;
			out_last_q <= o_last;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_byte   = out_byte_q;
	assign byte_index = idx_q;
	assign is_data    = is_data_q;
	assign status     = status_q;
	assign frame_len  = len_q;
	assign last       = out_last_q;

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FillW'(bsfrq_pkg::RingDepth))
		else $error("ring fill count exceeds depth");

	a_put_not_full: assert property (@(posedge clk) disable iff (!arst_n)
		put |-> !full)
		else $error("ring written while full");

	a_read_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		rd_issue |-> (fill_q != '0) && !put)
		else $error("ring read while empty or during a write");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> slot_free)
		else $error("pending result overwritten");

endmodule

`default_nettype wire

>>> tb/bsfrq_checker.sv
// Checker for the byte-stuffed frame ring queue: tracks the ring, the write framing and
// the read parser, and compares every result item against the predicted ones in order.
// Depends on bsfrq_pkg.
`timescale 1ns / 1ps

module bsfrq_checker
	import bsfrq_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [15:0] cfg_wdata,
	input  wire logic        in_valid,
	input  wire logic        in_ready,
	input  wire logic [1:0]  operation,
	input  wire logic [7:0]  data_byte,
	input  wire logic        first_of_frame,
	input  wire logic        last_of_frame,
	input  wire logic        out_valid,
	input  wire logic        out_ready,
	input  wire logic [7:0]  out_byte,
	input  wire logic [15:0] byte_index,
	input  wire logic        is_data,
	input  wire logic        status,
	input  wire logic [15:0] frame_len,
	input  wire logic        last,
	output int               fail_count,
	output int               owed_count
);

	typedef struct packed {
		logic [7:0]  out_byte;
		logic [15:0] byte_index;
		logic        is_data;
		logic        status;
		logic [15:0] frame_len;
		logic        last;
	} frame_result_t;

	frame_result_t owed_results[$];
	frame_result_t want;

	logic [7:0]  ring_copy [RingDepth];
	int          rd_at;
	int          wr_at;
	int          fill_level;
	int          enc_len;
	int          kept;
	bit          wr_failed;
	bit          esc_seen;
	bit          in_frame;
	logic [15:0] len_cap;

	function automatic bit ring_push(input logic [7:0] b);
		if (fill_level >= RingDepth)
			return 1'b0;
		ring_copy[wr_at] = b;
		wr_at = (wr_at + 1) % RingDepth;
		fill_level++;
		return 1'b1;
	endfunction

	function automatic void grow_len(input int n);
		enc_len = enc_len + n;
		if (enc_len > 16'hFFFF)
			enc_len = 16'hFFFF;
	endfunction

	task automatic owe(input logic [7:0] b, input logic [15:0] idx, input logic d,
			input logic st, input logic [15:0] len, input logic l);
		frame_result_t r;
		r.out_byte   = b;
		r.byte_index = idx;
		r.is_data    = d;
		r.status     = st;
		r.frame_len  = len;
		r.last       = l;
		owed_results.push_back(r);
	endtask

	task automatic apply_frame_op(input op_t op, input logic [7:0] db, input logic fst,
			input logic lst);
		logic [7:0]  c;
		logic [15:0] len;
		int          k;
		bit          closed;
		case (op)
			OpWrite: begin
				len = '0;
				if (fst) begin
					wr_failed = 1'b0;
					enc_len   = 2;
					if (!ring_push(FlagOpen))
						wr_failed = 1'b1;
				end
				if (!wr_failed) begin
					if (db == EscByte || db == FlagOpen || db == FlagClose) begin
						if (!ring_push(EscByte))
							wr_failed = 1'b1;
						else if (!ring_push(db ^ EscMask))
							wr_failed = 1'b1;
						else
							grow_len(2);
					end else if (!ring_push(db)) begin
						wr_failed = 1'b1;
					end else begin
						grow_len(1);
					end
				end
				if (!wr_failed && lst) begin
					if (!ring_push(FlagClose))
						wr_failed = 1'b1;
					else
						len = enc_len[15:0];
				end
				owe('0, '0, 1'b0, wr_failed, len, 1'b1);
			end
			OpEmpty: begin
				wr_failed = 1'b0;
				enc_len   = 2;
				if (!ring_push(FlagOpen))
					wr_failed = 1'b1;
				else if (!ring_push(FlagClose))
					wr_failed = 1'b1;
				owe('0, '0, 1'b0, wr_failed, wr_failed ? 16'd0 : 16'd2, 1'b1);
			end
			OpRead: begin
				esc_seen = 1'b0;
				in_frame = 1'b0;
				kept     = 0;
				k        = 0;
				closed   = 1'b0;
				while (!closed && fill_level > 0) begin
					c = ring_copy[rd_at];
					rd_at = (rd_at + 1) % RingDepth;
					fill_level--;
					if (c == EscByte) begin
						esc_seen = 1'b1;
					end else if (c == FlagOpen) begin
						kept     = 0;
						esc_seen = 1'b0;
						in_frame = 1'b1;
					end else if (c == FlagClose) begin
						in_frame = 1'b0;
						owe('0, '0, 1'b0, 1'b0, kept[15:0], 1'b1);
						closed = 1'b1;
					end else if (in_frame) begin
						if (esc_seen) begin
							c        = c ^ EscMask;
							esc_seen = 1'b0;
						end
						if (kept < len_cap && k < MaxDataResults) begin
							owe(c, kept[15:0], 1'b1, 1'b0, '0, 1'b0);
							k++;
							kept++;
						end
					end
				end
				if (!closed)
					owe('0, '0, 1'b0, 1'b1, '0, 1'b1);
			end
			default: ;
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			owed_results.delete();
			rd_at      = 0;
			wr_at      = 0;
			fill_level = 0;
			enc_len    = 0;
			kept       = 0;
			wr_failed  = 1'b0;
			esc_seen   = 1'b0;
			in_frame   = 1'b0;
			len_cap    = 16'd64;
			fail_count = 0;
			owed_count = 0;
		end else begin
			if (cfg_we)
				len_cap = cfg_wdata;
			if (in_valid && in_ready)
				apply_frame_op(operation, data_byte, first_of_frame, last_of_frame);
			if (out_valid && out_ready) begin
				if (owed_results.size() == 0) begin
					$error("result item with none expected: out_byte %0h frame_len %0d last %0b",
						out_byte, frame_len, last);
					fail_count++;
				end else begin
					want = owed_results.pop_front();
					if (out_byte !== want.out_byte) begin
						$error("out_byte: expected %0h, got %0h", want.out_byte, out_byte);
						fail_count++;
					end
					if (byte_index !== want.byte_index) begin
						$error("byte_index: expected %0d, got %0d", want.byte_index, byte_index);
						fail_count++;
					end
					if (is_data !== want.is_data) begin
						$error("is_data: expected %0b, got %0b", want.is_data, is_data);
						fail_count++;
					end
					if (status !== want.status) begin
						$error("status: expected %0b, got %0b", want.status, status);
						fail_count++;
					end
					if (frame_len !== want.frame_len) begin
						$error("frame_len: expected %0d, got %0d", want.frame_len, frame_len);
						fail_count++;
					end
					if (last !== want.last) begin
						$error("last: expected %0b, got %0b", want.last, last);
						fail_count++;
					end
				end
			end
			owed_count = owed_results.size();
		end
	end

endmodule

>>> tb/testbench.sv
// Top of the frame ring queue testbench: clock, reset, stimulus, receiver stalls, watchdog.
// Directed framing cases, then random phases over several caps.
// Depends on bsfrq_pkg, byte_stuffed_frame_ring_queue and bsfrq_checker.
`timescale 1ns / 1ps

module testbench;
	import bsfrq_pkg::*;

	localparam op_t OpUnused   = 2'd3;
	localparam int  StallLimit = 4000;
	localparam int  SettleGap  = 12;

	logic        clk            = 1'b0;
	logic        arst_n         = 1'b0;
	logic        cfg_we         = 1'b0;
	logic [15:0] cfg_wdata      = '0;
	logic        in_valid       = 1'b0;
	logic        in_ready;
	logic [1:0]  operation      = OpWrite;
	logic [7:0]  data_byte      = '0;
	logic        first_of_frame = 1'b0;
	logic        last_of_frame  = 1'b0;
	logic        out_valid;
	logic        out_ready      = 1'b0;
	logic [7:0]  out_byte;
	logic [15:0] byte_index;
	logic        is_data;
	logic        status;
	logic [15:0] frame_len;
	logic        last;

	int fail_count;
	int owed_count;
	int burst_left  = 0;
	int gap_max     = 6;
	int idle_cycles = 0;
	int rx_left     = 0;
	int rx_mode     = 0;
	int rx_tick     = 0;
	int rx_period   = 4;

	always #2 clk = ~clk;

	byte_stuffed_frame_ring_queue u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_wdata      (cfg_wdata),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.operation      (operation),
		.data_byte      (data_byte),
		.first_of_frame (first_of_frame),
		.last_of_frame  (last_of_frame),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.out_byte       (out_byte),
		.byte_index     (byte_index),
		.is_data        (is_data),
		.status         (status),
		.frame_len      (frame_len),
		.last           (last)
	);

	bsfrq_checker u_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_wdata      (cfg_wdata),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.operation      (operation),
		.data_byte      (data_byte),
		.first_of_frame (first_of_frame),
		.last_of_frame  (last_of_frame),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.out_byte       (out_byte),
		.byte_index     (byte_index),
		.is_data        (is_data),
		.status         (status),
		.frame_len      (frame_len),
		.last           (last),
		.fail_count     (fail_count),
		.owed_count     (owed_count)
	);

	function automatic logic [7:0] pick_byte();
		int r;
		r = $urandom_range(0, 99);
		if (r < 30)
			return EscByte + 8'($urandom_range(0, 2));
		else if (r < 36)
			return 8'h00;
		else if (r < 42)
			return 8'hFF;
		return 8'($urandom_range(0, 255));
	endfunction

	// one item; valid stays up into the next item unless the burst ends
	task automatic send_item(input op_t op, input logic [7:0] b, input logic f, input logic l);
		@(negedge clk);
		operation      = op;
		data_byte      = b;
		first_of_frame = f;
		last_of_frame  = l;
		in_valid       = 1'b1;
		do @(posedge clk); while (!in_ready);
		if (gap_max > 0) begin
			if (burst_left > 0) begin
				burst_left--;
			end else begin
				@(negedge clk);
				in_valid = 1'b0;
				repeat ($urandom_range(0, gap_max)) @(negedge clk);
				burst_left = $urandom_range(0, 12);
			end
		end
	endtask

	task automatic send_read();
		send_item(OpRead, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
			1'($urandom_range(0, 1)));
	endtask

	task automatic write_frame(input int n, input bit open, input bit close);
		for (int i = 0; i < n; i++)
			send_item(OpWrite, pick_byte(), open && i == 0, close && i == n - 1);
	endtask

	task automatic settle();
		@(negedge clk);
		in_valid = 1'b0;
		while (owed_count != 0) @(negedge clk);
		repeat (SettleGap) @(negedge clk);
	endtask

	task automatic set_len_cap(input logic [15:0] v);
		settle();
		@(negedge clk);
		cfg_we    = 1'b1;
		cfg_wdata = v;
		@(negedge clk);
		cfg_we    = 1'b0;
	endtask

	// receiver: always ready, coin flip, or periodic stalls, switched now and then
	always @(negedge clk) begin
		if (rx_left == 0) begin
			rx_mode   = $urandom_range(0, 2);
			rx_left   = $urandom_range(50, 300);
			rx_period = $urandom_range(2, 9);
			rx_tick   = 0;
		end
		rx_left--;
		rx_tick++;
		case (rx_mode)
			0:       out_ready = 1'b1;
			1:       out_ready = 1'($urandom_range(0, 1));
			default: out_ready = (rx_tick % rx_period) >= (rx_period / 2);
		endcase
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= StallLimit) begin
				$display("FAIL byte_stuffed_frame_ring_queue");
				$finish;
			end
		end
	end

	initial begin : stimulus
		logic [15:0] caps [6];
		int          r;
		int          n;
		int          sent;
		int          read_pct;
		caps = '{16'd0, 16'hFFFF, 16'd1, 16'd3, 16'd64, 16'd0};
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// empty ring, empty frame, extremes and escaped bytes
		send_read();
		send_item(OpEmpty, 8'h00, 1'b0, 1'b0);
		send_read();
		send_item(OpWrite, 8'h00, 1'b1, 1'b0);
		send_item(OpWrite, 8'hFF, 1'b0, 1'b0);
		send_item(OpWrite, EscByte, 1'b0, 1'b0);
		send_item(OpWrite, FlagOpen, 1'b0, 1'b0);
		send_item(OpWrite, FlagClose, 1'b0, 1'b1);
		send_read();
		// byte appended after a closed frame
		send_item(OpWrite, 8'h55, 1'b1, 1'b1);
		send_item(OpWrite, 8'h42, 1'b0, 1'b1);
		send_read();
		send_read();
		// restart inside one read
		send_item(OpWrite, 8'h11, 1'b1, 1'b0);
		send_item(OpWrite, 8'h22, 1'b0, 1'b0);
		send_item(OpWrite, 8'h33, 1'b1, 1'b0);
		send_item(OpWrite, 8'h44, 1'b0, 1'b1);
		send_read();
		send_item(OpUnused, 8'hA5, 1'b1, 1'b1);
		// fill the ring so that only the escape of the last byte fits
		send_item(OpWrite, EscByte, 1'b1, 1'b0);
		repeat (29) send_item(OpWrite, FlagOpen, 1'b0, 1'b0);
		send_item(OpWrite, 8'h41, 1'b0, 1'b0);
		send_item(OpWrite, 8'h42, 1'b0, 1'b0);
		send_item(OpWrite, FlagClose, 1'b0, 1'b1);
		send_item(OpWrite, 8'h43, 1'b0, 1'b1);
		send_item(OpEmpty, 8'h00, 1'b0, 1'b0);
		send_item(OpWrite, 8'h44, 1'b1, 1'b1);
		send_read();
		send_read();

		for (int p = 0; p < 6; p++) begin
			set_len_cap(p == 5 ? 16'($urandom_range(0, 65535)) : caps[p]);
			gap_max  = (p == 2) ? 0 : $urandom_range(2, 12);
			read_pct = (p == 3) ? 4 : 22;
			sent     = 0;
			while (sent < 27) begin
				r = $urandom_range(0, 99);
				if (r < read_pct) begin
					send_read();
					sent++;
				end else if (r < read_pct + 8) begin
					send_item(OpEmpty, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
						1'($urandom_range(0, 1)));
					sent++;
				end else if (r < read_pct + 11) begin
					send_item(OpUnused, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
						1'($urandom_range(0, 1)));
				end else if (r < read_pct + 16) begin
					send_item(OpWrite, pick_byte(), 1'($urandom_range(0, 1)),
						1'($urandom_range(0, 1)));
					sent++;
				end else if (r < read_pct + 20) begin
					n = $urandom_range(1, 6);
					write_frame(n, 1'b1, 1'b0);
					sent += n;
				end else begin
					n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 6);
					write_frame(n, 1'b1, 1'b1);
					sent += n;
				end
				if ($urandom_range(0, 39) == 0)
					settle();
			end
		end

		settle();
		repeat (20) @(negedge clk);
		if (fail_count == 0 && owed_count == 0)
			$display("PASS byte_stuffed_frame_ring_queue");
		else
			$display("FAIL byte_stuffed_frame_ring_queue");
		$finish;
	end

endmodule

>>> byte_stuffed_frame_ring_queue.f
rtl/bsfrq_pkg.sv
rtl/bsfrq_ring_mem.sv
rtl/byte_stuffed_frame_ring_queue.sv
tb/bsfrq_checker.sv
tb/testbench.sv
